FILE: design/dds_pkg.sv
// Shared constants and widths for the differential-drive wheel speed block.
package dds_pkg;

  localparam int ANG_W  = 16;
  localparam int SPD_W  = 16;
  localparam int WHL_W  = 14;
  localparam int RATE_W = 24;
  localparam int CFG_W  = 16;
  localparam int ERR_W  = 15;
  localparam int ANGX_W = 17;

  localparam int MC_W  = 24;
  localparam int MP_W  = 16;
  localparam int PR_W  = MC_W + MP_W;
  localparam int CNT_W = 4;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_ROT_GAIN = 1'b0;
  localparam logic REG_INV_STEP = 1'b1;

  localparam logic [CFG_W-1:0] ROT_GAIN_RST = 16'd12288;
  localparam logic [CFG_W-1:0] INV_STEP_RST = 16'd5120;

  // Angles carry 12 fraction bits.
  localparam logic signed [ANGX_W-1:0] PI_Q     = 17'sd12861;
  localparam logic signed [ANGX_W-1:0] TWO_PI_Q = 17'sd25722;
  localparam logic signed [ANGX_W-1:0] REV_TH_Q = 17'sd7074;
  localparam logic signed [ANGX_W-1:0] DEAD_Q   = 17'sd572;

  localparam logic [15:0] ROT_MIN_Q = 16'd2048;
  localparam logic [15:0] ROT_MAX_Q = 16'd12288;
  localparam logic [16:0] SPD_MIN_Q = 17'd3277;
  localparam logic [16:0] SPD_MAX_Q = 17'd16384;

  // Division by five through a reciprocal; inputs at or above the clamp
  // already exceed the rotation limit.
  localparam logic [MP_W-1:0] U_CLAMP = 16'd61445;
  localparam logic [MP_W-1:0] RECIP5  = 16'd52429;

endpackage

FILE: design/dds_ifs.sv
// Valid/ready channel interfaces for the input and result items.
interface dds_in_if;
  import dds_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] heading_error;
  logic signed [SPD_W-1:0] speed_demand;
  modport source (output valid, heading_error, speed_demand, input ready);
  modport sink (input valid, heading_error, speed_demand, output ready);
endinterface

interface dds_out_if;
  import dds_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [WHL_W-1:0] left_wheel;
  logic signed [WHL_W-1:0] right_wheel;
  logic                    reversing;
  modport source (output valid, left_wheel, right_wheel, reversing, input ready);
  modport sink (input valid, left_wheel, right_wheel, reversing, output ready);
endinterface

FILE: design/diff_drive_wheel_speed.sv
// Heading controller producing left and right wheel speed commands.
// An input is accepted only in the idle state, so an item runs to its result
// before the next is taken; three 16-step passes of the shared bit-serial
// multiplier carry out its rotation, divide-by-five and turn-rate products.
// A new input is accepted while an earlier result still waits on the output.
// Synchronous active-low reset restores gains to their defaults and clears the turn rate.
module diff_drive_wheel_speed (
  input  logic                          clk,
  input  logic                          rst_n,
  dds_in_if.sink                        in_if,
  dds_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dds_pkg::PADDR_W-1:0]   paddr,
  input  logic [dds_pkg::PDATA_W-1:0]   pwdata,
  output logic [dds_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_SEL, S_MROT, S_DSET, S_DIV5, S_RSET, S_MRATE, S_RATE,
    S_SUM, S_OUT
  } state_t;

  state_t                   state_r;
  logic [CFG_W-1:0]         rot_gain_r;
  logic [CFG_W-1:0]         inv_step_r;
  logic signed [RATE_W-1:0] turn_rate_r;
  logic signed [ANG_W-1:0]  hdg_r;
  logic signed [SPD_W-1:0]  spd_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  erate_r;
  logic                     back_r;
  logic [PR_W-1:0]          mul_r;
  logic [MC_W-1:0]          mc_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [13:0]              rotq_r;
  logic signed [15:0]       rot_r;
  logic signed [15:0]       spdl_r;
  logic signed [15:0]       left_r;
  logic signed [15:0]       right_r;
  logic                     out_valid_r;
  logic [WHL_W-1:0]         left_out_r;
  logic [WHL_W-1:0]         right_out_r;
  logic                     rev_out_r;

  logic                     reg_idx;
  logic                     cfg_wr;
  logic                     out_load;
  logic [MC_W:0]            add_s;
  logic [PR_W-1:0]          mul_nxt;
  logic signed [ANGX_W-1:0] h_ext;
  logic signed [ANGX_W-1:0] err_nxt;
  logic signed [ANGX_W-1:0] e_ext;
  logic signed [ANGX_W-1:0] e_mag;
  logic signed [ANGX_W-1:0] e_turn;
  logic                     back_nxt;
  logic signed [ANGX_W-1:0] erate_nxt;
  logic signed [ANGX_W-1:0] er_ext;
  logic signed [ANGX_W-1:0] er_mag;
  logic [MC_W-1:0]          tr_mag;
  logic [25:0]              u_val;
  logic [MP_W-1:0]          u_nxt;
  logic [15:0]              q_val;
  logic [15:0]              rotq_nxt;
  logic [16:0]              s_ext;
  logic [16:0]              s_mag;
  logic [16:0]              s_lim;
  logic [15:0]              spdl_nxt;
  logic [RATE_W-1:0]        rate_mag;
  logic [RATE_W-1:0]        rate_nxt;
  logic [15:0]              rot_nxt;
  logic signed [15:0]       sum_a;
  logic signed [15:0]       sum_d;

  function automatic logic [WHL_W-1:0] wheel_cmd(input logic signed [15:0] s);
    logic [15:0] mag;
    logic [20:0] m25;
    logic [WHL_W-1:0] w;
    mag = s[15] ? (~s + 16'd1) : s;
    m25 = ({5'd0, mag} << 4) + ({5'd0, mag} << 3) + {5'd0, mag};
    w = m25[20:7];
    return s[15] ? (~w + 14'd1) : w;
  endfunction

  assign reg_idx = paddr[PADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = {{(PDATA_W-CFG_W){1'b0}},
                    (reg_idx == REG_INV_STEP) ? inv_step_r : rot_gain_r};

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.left_wheel  = left_out_r;
  assign out_if.right_wheel = right_out_r;
  assign out_if.reversing   = rev_out_r;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  assign add_s   = {1'b0, mul_r[PR_W-1:MP_W]} + (mul_r[0] ? {1'b0, mc_r} : '0);
  assign mul_nxt = {add_s, mul_r[MP_W-1:1]};

  always_comb begin
    h_ext = {hdg_r[ANG_W-1], hdg_r};
    if (h_ext > PI_Q) begin
      err_nxt = h_ext - TWO_PI_Q;
    end else if (h_ext < -PI_Q) begin
      err_nxt = h_ext + TWO_PI_Q;
    end else begin
      err_nxt = h_ext;
    end
  end

  always_comb begin
    e_ext    = {{(ANGX_W-ERR_W){err_r[ERR_W-1]}}, err_r};
    e_mag    = e_ext[ANGX_W-1] ? -e_ext : e_ext;
    back_nxt = (e_mag > REV_TH_Q);
    e_turn   = e_ext + PI_Q;
    if (!back_nxt) begin
      erate_nxt = e_ext;
    end else if (e_turn > PI_Q) begin
      erate_nxt = e_turn - TWO_PI_Q;
    end else begin
      erate_nxt = e_turn;
    end
    tr_mag = turn_rate_r[RATE_W-1] ? (~turn_rate_r + 24'd1) : turn_rate_r;
  end

  always_comb begin
    u_val = mul_r[PR_W-1:14];
    u_nxt = (u_val >= {10'd0, U_CLAMP}) ? U_CLAMP : u_val[MP_W-1:0];
    q_val = mul_r[33:18];
    if (q_val == 16'd0) begin
      rotq_nxt = 16'd0;
    end else if (q_val < ROT_MIN_Q) begin
      rotq_nxt = ROT_MIN_Q;
    end else if (q_val > ROT_MAX_Q) begin
      rotq_nxt = ROT_MAX_Q;
    end else begin
      rotq_nxt = q_val;
    end
    s_ext = {spd_r[SPD_W-1], spd_r};
    s_mag = spd_r[SPD_W-1] ? (~s_ext + 17'd1) : s_ext;
    if (s_mag == 17'd0) begin
      s_lim = 17'd0;
    end else if (s_mag < SPD_MIN_Q) begin
      s_lim = SPD_MIN_Q;
    end else if (s_mag > SPD_MAX_Q) begin
      s_lim = SPD_MAX_Q;
    end else begin
      s_lim = s_mag;
    end
    spdl_nxt = spd_r[SPD_W-1] ? (~s_lim[15:0] + 16'd1) : s_lim[15:0];
  end

  always_comb begin
    er_ext   = {{(ANGX_W-ERR_W){erate_r[ERR_W-1]}}, erate_r};
    er_mag   = er_ext[ANGX_W-1] ? -er_ext : er_ext;
    rate_mag = (er_mag < DEAD_Q) ? '0 : {2'd0, mul_r[29:8]};
    rate_nxt = erate_r[ERR_W-1] ? (~rate_mag + 24'd1) : rate_mag;
    rot_nxt  = turn_rate_r[RATE_W-1] ? (~{2'd0, rotq_r} + 16'd1) : {2'd0, rotq_r};
    sum_a    = spdl_r + rot_r;
    sum_d    = spdl_r - rot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rot_gain_r  <= ROT_GAIN_RST;
      inv_step_r  <= INV_STEP_RST;
      turn_rate_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr) begin
        if (reg_idx == REG_INV_STEP) begin
          inv_step_r <= pwdata[CFG_W-1:0];
        end else begin
          rot_gain_r <= pwdata[CFG_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            hdg_r   <= in_if.heading_error;
            spd_r   <= in_if.speed_demand;
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          err_r   <= err_nxt[ERR_W-1:0];
          state_r <= S_SEL;
        end
        S_SEL: begin
          back_r  <= back_nxt;
          erate_r <= erate_nxt[ERR_W-1:0];
          mc_r    <= tr_mag;
          mul_r   <= {{MC_W{1'b0}}, rot_gain_r};
          cnt_r   <= '0;
          state_r <= S_MROT;
        end
        S_MROT: begin
          mul_r <= mul_nxt;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == '1) begin
            state_r <= S_DSET;
          end
        end
        S_DSET: begin
          mc_r    <= {{(MC_W-MP_W){1'b0}}, RECIP5};
          mul_r   <= {{MC_W{1'b0}}, u_nxt};
          state_r <= S_DIV5;
        end
        S_DIV5: begin
          mul_r <= mul_nxt;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == '1) begin
            state_r <= S_RSET;
          end
        end
        S_RSET: begin
          rotq_r  <= rotq_nxt[13:0];
          spdl_r  <= spdl_nxt;
          mc_r    <= {{(MC_W-ANGX_W){1'b0}}, er_mag};
          mul_r   <= {{MC_W{1'b0}}, inv_step_r};
          state_r <= S_MRATE;
        end
        S_MRATE: begin
          mul_r <= mul_nxt;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == '1) begin
            state_r <= S_RATE;
          end
        end
        S_RATE: begin
          rot_r       <= rot_nxt;
          turn_rate_r <= rate_nxt;
          state_r     <= S_SUM;
        end
        S_SUM: begin
          left_r  <= back_r ? -sum_a : sum_d;
          right_r <= back_r ? -sum_d : sum_a;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            left_out_r  <= wheel_cmd(left_r);
            right_out_r <= wheel_cmd(right_r);
            rev_out_r   <= back_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench for the differential-drive wheel speed block: stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb_top;
  import dds_pkg::*;

  typedef struct packed {
    logic signed [WHL_W-1:0] left_wheel;
    logic signed [WHL_W-1:0] right_wheel;
    logic                    reversing;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dds_in_if  hdg_ch ();
  dds_out_if whl_ch ();

  diff_drive_wheel_speed dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (hdg_ch),
    .out_if  (whl_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  wheel_cmd_t  wheel_cmds_due[$];
  int unsigned err_count = 0;
  longint      pred_turn_rate = 0;
  longint      pred_rot_gain = longint'(ROT_GAIN_RST);
  longint      pred_inv_step = longint'(INV_STEP_RST);
  bit          src_gaps_on = 1'b1;
  bit          sink_gaps_on = 1'b1;
  int unsigned sink_hold_cycles = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic longint wrap_heading(longint a);
    while (a > longint'(PI_Q))
      a -= longint'(TWO_PI_Q);
    while (a < -longint'(PI_Q))
      a += longint'(TWO_PI_Q);
    return a;
  endfunction

  function automatic longint clamp_magnitude(longint v, longint lo, longint hi);
    if (v > 0) begin
      if (v > hi) v = hi;
      if (v < lo) v = lo;
    end else if (v < 0) begin
      if (v < -hi) v = -hi;
      if (v > -lo) v = -lo;
    end
    return v;
  endfunction

  function automatic longint rate_from_heading(longint err);
    longint a;
    longint r;
    a = (err < 0) ? -err : err;
    if (a < longint'(DEAD_Q))
      return 0;
    r = (err * pred_inv_step) / 256;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r;
  endfunction

  function automatic logic signed [WHL_W-1:0] wheel_command(longint sum);
    longint w;
    w = (sum * 800) / 4096;
    if (w > 5600) w = 5600;
    if (w < -5600) w = -5600;
    return w[WHL_W-1:0];
  endfunction

  function automatic wheel_cmd_t predict_wheels(logic signed [ANG_W-1:0] hdg,
                                                logic signed [SPD_W-1:0] spd_in);
    longint     err;
    longint     spd;
    longint     rot;
    longint     mag;
    longint     lw;
    longint     rw;
    wheel_cmd_t cmd;
    err = wrap_heading(longint'(hdg));
    spd = longint'(spd_in);
    rot = (pred_turn_rate * pred_rot_gain) / (20 * 4096);
    mag = (err < 0) ? -err : err;
    rot = clamp_magnitude(rot, longint'(ROT_MIN_Q), longint'(ROT_MAX_Q));
    spd = clamp_magnitude(spd, longint'(SPD_MIN_Q), longint'(SPD_MAX_Q));
    cmd.reversing = (mag > longint'(REV_TH_Q));
    if (cmd.reversing) begin
      pred_turn_rate = rate_from_heading(wrap_heading(err + longint'(PI_Q)));
      lw = -(spd + rot);
      rw = -(spd - rot);
    end else begin
      pred_turn_rate = rate_from_heading(err);
      lw = spd - rot;
      rw = spd + rot;
    end
    cmd.left_wheel = wheel_command(lw);
    cmd.right_wheel = wheel_command(rw);
    return cmd;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_heading(logic signed [ANG_W-1:0] hdg, logic signed [SPD_W-1:0] spd);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      hdg_ch.valid <= 1'b0;
      hdg_ch.heading_error <= ANG_W'($urandom);
      hdg_ch.speed_demand <= SPD_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    hdg_ch.valid <= 1'b1;
    hdg_ch.heading_error <= hdg;
    hdg_ch.speed_demand <= spd;
    do @(posedge clk); while (!hdg_ch.ready);
    wheel_cmds_due.push_back(predict_wheels(hdg, spd));
  endtask

  task automatic drain_results();
    hdg_ch.valid <= 1'b0;
    while (wheel_cmds_due.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwdata <= $urandom;
    if (idx == REG_ROT_GAIN)
      pred_rot_gain = longint'(value[CFG_W-1:0]);
    else
      pred_inv_step = longint'(value[CFG_W-1:0]);
    if (readback !== {{(PDATA_W-CFG_W){1'b0}}, value[CFG_W-1:0]})
      report_mismatch($sformatf("register %0d readback", idx), longint'(readback),
                      longint'(value[CFG_W-1:0]));
    @(posedge clk);
  endtask

  function automatic logic signed [ANG_W-1:0] rand_heading();
    int unsigned pick;
    int signed   edge_val;
    int signed   sgn;
    pick = $urandom_range(0, 9);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    if (pick < 5)
      return ANG_W'($urandom);
    if (pick < 8)
      return ANG_W'(int'($urandom_range(0, 2 * 12861)) - 12861);
    case ($urandom_range(0, 2))
      0: edge_val = int'(REV_TH_Q);
      1: edge_val = int'(DEAD_Q);
      default: edge_val = int'(PI_Q);
    endcase
    return ANG_W'(sgn * (edge_val + int'($urandom_range(0, 6)) - 3));
  endfunction

  function automatic logic signed [SPD_W-1:0] rand_speed();
    if ($urandom_range(0, 1))
      return SPD_W'($urandom);
    return SPD_W'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  always @(posedge clk) begin
    wheel_cmd_t want;
    if (rst_n && whl_ch.valid && whl_ch.ready) begin
      if (wheel_cmds_due.size() == 0) begin
        report_mismatch("result with no item pending", 0, 0);
      end else begin
        want = wheel_cmds_due.pop_front();
        if (whl_ch.left_wheel !== want.left_wheel)
          report_mismatch("left_wheel", longint'(whl_ch.left_wheel),
                          longint'(want.left_wheel));
        if (whl_ch.right_wheel !== want.right_wheel)
          report_mismatch("right_wheel", longint'(whl_ch.right_wheel),
                          longint'(want.right_wheel));
        if (whl_ch.reversing !== want.reversing)
          report_mismatch("reversing", longint'(whl_ch.reversing),
                          longint'(want.reversing));
      end
    end
  end

  initial begin : result_sink
    int unsigned gap;
    whl_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_cycles != 0) begin
        whl_ch.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end
      gap = sink_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        whl_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      whl_ch.ready <= 1'b1;
      do @(posedge clk); while (!whl_ch.valid);
    end
  end

  task automatic test_register_access();
    set_reg(REG_ROT_GAIN, 32'hFFFF_FFFF);
    set_reg(REG_INV_STEP, 32'h0000_0000);
    set_reg(REG_ROT_GAIN, {16'($urandom_range(0, 65535)), 16'h0000});
    set_reg(REG_INV_STEP, {16'h0000, 16'hFFFF});
    set_reg(REG_ROT_GAIN, $urandom);
    set_reg(REG_INV_STEP, $urandom);
    set_reg(REG_ROT_GAIN, PDATA_W'(ROT_GAIN_RST));
    set_reg(REG_INV_STEP, PDATA_W'(INV_STEP_RST));
  endtask

  task automatic test_directed_headings();
    int hd[22] = '{0, 32767, -32768, 12861, 12862, -12861, -12862, 7074, 7075, -7074,
                   -7075, 571, 572, -572, -571, 25722, -25723, 3000, -3000, 12000,
                   -9000, 1};
    int sp[22] = '{0, 32767, -32768, 1, -1, 3276, 3277, -3277, 16384, 16385,
                   -16385, -16384, 8000, 0, 32767, -32768, 5000, 0, 20000, -1,
                   -20000, 4096};
    foreach (hd[i])
      send_heading(ANG_W'(hd[i]), SPD_W'(sp[i]));
    drain_results();
  endtask

  task automatic test_gain_extremes();
    set_reg(REG_ROT_GAIN, 32'h0000_FFFF);
    set_reg(REG_INV_STEP, 32'h0000_FFFF);
    repeat (8) send_heading(rand_heading(), rand_speed());
    drain_results();
    set_reg(REG_INV_STEP, 32'h0000_0000);
    repeat (6) send_heading(rand_heading(), rand_speed());
    drain_results();
    set_reg(REG_ROT_GAIN, 32'h0000_0000);
    set_reg(REG_INV_STEP, PDATA_W'(INV_STEP_RST));
    repeat (6) send_heading(rand_heading(), rand_speed());
    drain_results();
    set_reg(REG_ROT_GAIN, PDATA_W'(ROT_GAIN_RST));
  endtask

  task automatic test_output_backpressure();
    src_gaps_on = 1'b0;
    sink_hold_cycles = 500;
    repeat (14) send_heading(rand_heading(), rand_speed());
    drain_results();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          set_reg(REG_ROT_GAIN, PDATA_W'(ROT_GAIN_RST));
          set_reg(REG_INV_STEP, PDATA_W'(INV_STEP_RST));
        end
        1: begin
          set_reg(REG_ROT_GAIN, 32'h0000_FFFF);
          set_reg(REG_INV_STEP, 32'h0000_FFFF);
        end
        2: begin
          set_reg(REG_ROT_GAIN, 32'h0000_0000);
          set_reg(REG_INV_STEP, 32'h0000_0000);
        end
        default: begin
          set_reg(REG_ROT_GAIN, $urandom);
          set_reg(REG_INV_STEP, $urandom);
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) begin
          src_gaps_on = $urandom_range(0, 3) != 0;
          sink_gaps_on = $urandom_range(0, 3) != 0;
        end
        if (n == 100)
          drain_results();
        send_heading(rand_heading(), rand_speed());
      end
      drain_results();
    end
  endtask

  initial begin
    hdg_ch.valid = 1'b0;
    hdg_ch.heading_error = '0;
    hdg_ch.speed_demand = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_headings();
    test_gain_extremes();
    test_output_backpressure();
    test_random_traffic();
    drain_results();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
design/dds_pkg.sv
design/dds_ifs.sv
design/diff_drive_wheel_speed.sv
tb/tb_top.sv
